// ===== design/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

  // Field widths
  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_BASE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BASE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_TEMPCO    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TEMPCO  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_REFERENCE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SLOPE     = 3'd5;

  // Factory calibration defaults
  localparam logic [COEFF_W-1:0] RST_SENS_BASE      = 16'd40127;
  localparam logic [COEFF_W-1:0] RST_OFFSET_BASE    = 16'd36924;
  localparam logic [COEFF_W-1:0] RST_SENS_TEMPCO    = 16'd23317;
  localparam logic [COEFF_W-1:0] RST_OFFSET_TEMPCO  = 16'd23282;
  localparam logic [COEFF_W-1:0] RST_TEMP_REFERENCE = 16'd33464;
  localparam logic [COEFF_W-1:0] RST_TEMP_SLOPE     = 16'd28312;

  // 20.00 C in hundredths
  localparam int TEMP_REF_CENTI = 2000;

  // Register stages from input to output register
  localparam int NUM_STAGES = 9;

  typedef struct packed {
    logic [COEFF_W-1:0] sens_base;
    logic [COEFF_W-1:0] offset_base;
    logic [COEFF_W-1:0] sens_tempco;
    logic [COEFF_W-1:0] offset_tempco;
    logic [COEFF_W-1:0] temp_reference;
    logic [COEFF_W-1:0] temp_slope;
  } coeff_t;

endpackage

`default_nettype wire

// ===== design/bpc_core.sv =====
`default_nettype none

module bpc_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bpc_pkg::coeff_t                   coeffs,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bpc_pkg::RAW_W-1:0]         raw_pressure,
  input  wire logic [bpc_pkg::RAW_W-1:0]         raw_temperature,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [bpc_pkg::TEMP_W-1:0]      temperature_centi,
  output logic signed [bpc_pkg::PRES_W-1:0]      pressure_centi
);

  localparam int N = bpc_pkg::NUM_STAGES;

  logic [N-1:0] vld;
  logic [N-1:0] adv;

  // Stage advances when empty or when the next one takes its word
  assign adv[N-1] = !vld[N-1] || out_ready;
  for (genvar i = 0; i < N - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[N-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 0: capture D1, form dT = D2 - ref*2^8
  logic        [23:0] s0_d1;
  logic signed [24:0] s0_dt;
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_d1 <= raw_pressure;
      s0_dt <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coeffs.temp_reference, 8'b0});
    end
  end

  // Stage 1: the four products of dT
  logic        [23:0] s1_d1;
  logic signed [41:0] s1_tprod;
  logic signed [41:0] s1_oprod;
  logic signed [41:0] s1_sprod;
  logic signed [49:0] s1_dtsq;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d1    <= s0_d1;
      s1_tprod <= s0_dt * $signed({1'b0, coeffs.temp_slope});
      s1_oprod <= s0_dt * $signed({1'b0, coeffs.offset_tempco});
      s1_sprod <= s0_dt * $signed({1'b0, coeffs.sens_tempco});
      s1_dtsq  <= s0_dt * s0_dt;
    end
  end

  // Stage 2: first-order TEMP, OFF, SENS; cold flag and distance below 20 C
  logic        [23:0] s2_d1;
  logic signed [18:0] s2_temp1;
  logic               s2_neg;
  logic        [17:0] s2_x;
  logic        [18:0] s2_t2;
  logic signed [39:0] s2_off1;
  logic signed [39:0] s2_sens1;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_d1    <= s1_d1;
      s2_temp1 <= 19'(bpc_pkg::TEMP_REF_CENTI + (s1_tprod >>> 23));
      // TEMP drops below 20 C exactly when the slope product is negative
      s2_neg   <= s1_tprod[41];
      s2_x     <= 18'(-(s1_tprod >>> 23));
      s2_t2    <= s1_dtsq[49:31];
      s2_off1  <= $signed({8'b0, coeffs.offset_base, 16'b0}) + 40'(s1_oprod >>> 7);
      s2_sens1 <= $signed({9'b0, coeffs.sens_base, 15'b0}) + 40'(s1_sprod >>> 8);
    end
  end

  // Stage 3: square of the distance below 20 C, second-order temperature
  logic        [23:0] s3_d1;
  logic signed [18:0] s3_temp;
  logic               s3_neg;
  logic        [35:0] s3_sq;
  logic signed [39:0] s3_off1;
  logic signed [39:0] s3_sens1;
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d1    <= s2_d1;
      s3_temp  <= s2_neg ? s2_temp1 - $signed(s2_t2) : s2_temp1;
      s3_neg   <= s2_neg;
      s3_sq    <= s2_x * s2_x;
      s3_off1  <= s2_off1;
      s3_sens1 <= s2_sens1;
    end
  end

  // Stage 4: subtract OFF2 = 5*sq/2 and SENS2 = 5*sq/4 when cold
  logic        [37:0] sq5;
  logic signed [39:0] off2;
  logic signed [39:0] sens2;
  assign sq5   = {s3_sq, 2'b00} + {2'b00, s3_sq};
  assign off2  = s3_neg ? $signed({3'b0, sq5[37:1]}) : 40'sd0;
  assign sens2 = s3_neg ? $signed({4'b0, sq5[37:2]}) : 40'sd0;

  logic        [23:0] s4_d1;
  logic signed [18:0] s4_temp;
  logic signed [39:0] s4_off;
  logic signed [39:0] s4_sens;
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d1   <= s3_d1;
      s4_temp <= s3_temp;
      s4_off  <= s3_off1 - off2;
      s4_sens <= s3_sens1 - sens2;
    end
  end

  // Stage 5: D1*SENS as two partial products on the low and high halves
  logic signed [18:0] s5_temp;
  logic signed [39:0] s5_off;
  logic        [43:0] s5_plo;
  logic signed [44:0] s5_phi;
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_temp <= s4_temp;
      s5_off  <= s4_off;
      s5_plo  <= s4_d1 * s4_sens[19:0];
      s5_phi  <= $signed({1'b0, s4_d1}) * $signed(s4_sens[39:20]);
    end
  end

  // Stage 6: join the partial products
  logic signed [18:0] s6_temp;
  logic signed [39:0] s6_off;
  logic signed [63:0] s6_pp;
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_temp <= s5_temp;
      s6_off  <= s5_off;
      s6_pp   <= (64'(s5_phi) <<< 20) + $signed({20'b0, s5_plo});
    end
  end

  // Stage 7: D1*SENS/2^21 - OFF
  logic signed [18:0] s7_temp;
  logic signed [44:0] s7_q;
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_temp <= s6_temp;
      s7_q    <= 45'(s6_pp >>> 21) - 45'(s6_off);
    end
  end

  // Stage 8: output register; the range of q keeps P within 32 bits, so no
  // saturation is needed and a sign-extending select suffices
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      temperature_centi <= s7_temp;
      pressure_centi    <= 32'(s7_q >>> 15);
    end
  end

endmodule

`default_nettype wire

// ===== design/baro_pressure_temp_compensation.sv =====
`default_nettype none

// Barometric pressure and temperature compensation. Each input word carries a
// raw pressure (D1) and raw temperature (D2) conversion; each output word
// carries the compensated temperature in 0.01 C and pressure in 0.01 mbar,
// including the second-order correction below 20 C. The datapath is a nine
// stage pipeline built around the dT products and the split D1*SENS multiply:
// one word is accepted every cycle unless back-pressure has filled every stage,
// and back-pressure on the output only stalls stages that hold a word. The
// six calibration words are written through the cfg port (index 0 to 5 in the
// order sens base, offset base, sens tempco, offset tempco, temperature
// reference, temperature slope); write them only while no word is in flight.
module baro_pressure_temp_compensation (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [bpc_pkg::COEFF_W-1:0]         cfg_data,
  // Input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [47:0]                         s_tdata,  // raw_pressure, raw_temperature
  // Output stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [55:0]                              m_tdata   // temperature_centi, pressure_centi, pad
);

  bpc_pkg::coeff_t coeffs;

  assign cfg_ready = 1'b1;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs.sens_base      <= bpc_pkg::RST_SENS_BASE;
      coeffs.offset_base    <= bpc_pkg::RST_OFFSET_BASE;
      coeffs.sens_tempco    <= bpc_pkg::RST_SENS_TEMPCO;
      coeffs.offset_tempco  <= bpc_pkg::RST_OFFSET_TEMPCO;
      coeffs.temp_reference <= bpc_pkg::RST_TEMP_REFERENCE;
      coeffs.temp_slope     <= bpc_pkg::RST_TEMP_SLOPE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::REG_SENS_BASE:      coeffs.sens_base      <= cfg_data;
        bpc_pkg::REG_OFFSET_BASE:    coeffs.offset_base    <= cfg_data;
        bpc_pkg::REG_SENS_TEMPCO:    coeffs.sens_tempco    <= cfg_data;
        bpc_pkg::REG_OFFSET_TEMPCO:  coeffs.offset_tempco  <= cfg_data;
        bpc_pkg::REG_TEMP_REFERENCE: coeffs.temp_reference <= cfg_data;
        bpc_pkg::REG_TEMP_SLOPE:     coeffs.temp_slope     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi;
  logic signed [bpc_pkg::PRES_W-1:0] pressure_centi;

  bpc_core u_core (
    .clk               (clk),
    .rst               (rst),
    .coeffs            (coeffs),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .raw_pressure      (s_tdata[23:0]),
    .raw_temperature   (s_tdata[47:24]),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
  );

  // Pack the result word, zero pad to whole bytes
  assign m_tdata = {5'b0, pressure_centi, temperature_centi};

  // Input stalls only when every stage is full and the output is held
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held output word");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output word valid straight after reset");

  // A slope write lands in its register
  a_cfg_slope: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == bpc_pkg::REG_TEMP_SLOPE)
      |=> coeffs.temp_slope == $past(cfg_data))
    else $error("temperature slope write lost");

endmodule

`default_nettype wire
